### hw/rtl/npc_pkg.sv
`default_nettype none

package npc_pkg;

   localparam int CHAN_W         = 8;
   localparam int ENTRY_W        = 3 * CHAN_W;
   localparam int PAIR_W         = 2 * ENTRY_W;
   localparam int PAIR_COUNT     = 8;
   localparam int STORED_ENTRIES = 2 * PAIR_COUNT;
   localparam int CSR_INDEX_W    = 3;
   localparam int IDX_W          = 4;
   localparam int SQ_W           = 2 * CHAN_W;
   // 3 * 255^2 = 195075 fits in 18 bits
   localparam int DIST_W         = SQ_W + 2;

   // power-up palette, two entries per word, R in the low byte of each entry
   localparam logic [PAIR_W-1:0] PAIR_RESET [PAIR_COUNT] = '{
      48'd16711935,
      48'd150558072032358,
      48'd280888577180740,
      48'd243943259592123,
      48'd131357269714653,
      48'd150559782194380,
      48'd205976889567829,
      48'd262709976026316
   };

   typedef struct packed {
      logic              valid;
      logic [DIST_W-1:0] distance;
      logic [IDX_W-1:0]  idx;
   } cand_type;

   // challenger only takes over on a strictly smaller distance: lower index wins ties
   function automatic logic replaces(input cand_type incumbent, input cand_type challenger);
      return challenger.valid
             && (!incumbent.valid || (challenger.distance < incumbent.distance));
   endfunction

endpackage

`default_nettype wire

### hw/rtl/npc_argmin.sv
`default_nettype none

module npc_argmin #(
   parameter int PALETTE_ENTRIES = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic [npc_pkg::DIST_W-1:0]    in_dist [PALETTE_ENTRIES],
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic [npc_pkg::IDX_W-1:0]          out_index
);

   localparam int Groups = (PALETTE_ENTRIES + 3) / 4;
   localparam int Padded = Groups * 4;
   localparam int IdxW   = npc_pkg::IDX_W;

   npc_pkg::cand_type cand [Padded];
   npc_pkg::cand_type grp_in [Groups];
   npc_pkg::cand_type grp_ff [Groups];
   logic              grp_valid_ff;
   logic              grp_ready;
   logic [IdxW-1:0]   index_in;
   logic [IdxW-1:0]   index_ff;
   logic              out_valid_ff;
   logic              out_load;

   // unused slots of the last group never win
   for (genvar k = 0; k < Padded; k++) begin : g_cand
      if (k < PALETTE_ENTRIES) begin : g_used
         assign cand[k] = '{valid: 1'b1, distance: in_dist[k], idx: IdxW'(k)};
      end else begin : g_pad
         assign cand[k] = '{valid: 1'b0, distance: '0, idx: IdxW'(k)};
      end
   end

   // first level: best of each group of four
   always_comb begin
      npc_pkg::cand_type best;
      for (int g = 0; g < Groups; g++) begin
         best = cand[4*g];
         for (int j = 1; j < 4; j++) begin
            if (npc_pkg::replaces(best, cand[4*g+j])) begin
               best = cand[4*g+j];
            end
         end
         grp_in[g] = best;
      end
   end

   // second level: best over the groups, in index order
   always_comb begin
      npc_pkg::cand_type best;
      best = grp_ff[0];
      for (int g = 1; g < Groups; g++) begin
         if (npc_pkg::replaces(best, grp_ff[g])) begin
            best = grp_ff[g];
         end
      end
      index_in = best.idx;
   end

   assign out_load  = !out_valid_ff || out_ready;
   assign grp_ready = !grp_valid_ff || out_load;
   assign in_ready  = grp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (grp_ready) begin
            grp_valid_ff <= in_valid;
         end
         if (out_load) begin
            out_valid_ff <= grp_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (grp_ready) begin
         grp_ff <= grp_in;
      end
      if (out_load) begin
         index_ff <= index_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_index = index_ff;

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> (!grp_valid_ff && !out_valid_ff))
      else $error("argmin not empty after reset");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (32'(index_ff) < PALETTE_ENTRIES))
      else $error("winning index beyond searched entries");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ready) |=> (out_valid_ff && $stable(index_ff)))
      else $error("held result changed under stall");

endmodule

`default_nettype wire

### hw/rtl/nearest_palette_color.sv
// Nearest palette colour: maps one RGB pixel per item to the closest of the
// first PALETTE_ENTRIES palette entries by squared Euclidean distance.
//
// req_* channel carries the pixel, rsp_* returns index and RGB of the chosen
// entry, one result item per pixel, in order. An item moves on a rising edge
// with valid high and stall low.
// csr_* writes one 48-bit palette pair (two entries) per cycle with the write
// enable high; write only while no items are in flight.
//
// Throughput: one item per cycle while rsp_stall is low. Pipe stages, in
// order: abs difference, square, channel sum, best of four, best of groups,
// colour lookup / output register.
// Ties go to the lowest index.
//
// Reset: synchronous; empties the pipe and restores the built-in palette.
// rsp_stall backs up stage by stage; req_stall rises only once the first
// stage is full and cannot move, so bubbles are squeezed out first.
`default_nettype none

module nearest_palette_color #(
   parameter int PALETTE_ENTRIES = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // pixel in
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [npc_pkg::CHAN_W-1:0]         req_pixel_red,
   input  wire logic [npc_pkg::CHAN_W-1:0]         req_pixel_green,
   input  wire logic [npc_pkg::CHAN_W-1:0]         req_pixel_blue,
   // result out
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [npc_pkg::IDX_W-1:0]               rsp_chosen_index,
   output logic [npc_pkg::CHAN_W-1:0]              rsp_chosen_red,
   output logic [npc_pkg::CHAN_W-1:0]              rsp_chosen_green,
   output logic [npc_pkg::CHAN_W-1:0]              rsp_chosen_blue,
   // palette write port
   input  wire logic                               csr_write_enable,
   input  wire logic [npc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [npc_pkg::PAIR_W-1:0]         csr_data
);

   localparam int ChanW  = npc_pkg::CHAN_W;
   localparam int SqW    = npc_pkg::SQ_W;
   localparam int DistW  = npc_pkg::DIST_W;
   localparam int EntryW = npc_pkg::ENTRY_W;

   // ---------------- palette registers ----------------
   logic [npc_pkg::PAIR_W-1:0] pair_ff [npc_pkg::PAIR_COUNT];
   logic [EntryW-1:0]          palette [npc_pkg::STORED_ENTRIES];

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_ff <= npc_pkg::PAIR_RESET;
      end else if (csr_write_enable) begin
         pair_ff[csr_index] <= csr_data;
      end
   end

   // even entry in the low half of a pair, odd entry in the high half
   always_comb begin
      for (int e = 0; e < npc_pkg::STORED_ENTRIES; e++) begin
         palette[e] = pair_ff[e/2][(e%2)*EntryW +: EntryW];
      end
   end

   // ---------------- stage handshake ----------------
   logic valid1_ff, valid2_ff, valid3_ff, valid6_ff;
   logic ready1, ready2, ready3, ready6;
   logic am_in_ready, am_out_valid;
   logic [npc_pkg::IDX_W-1:0] am_index;

   assign ready6 = !valid6_ff || !rsp_stall;
   assign ready3 = !valid3_ff || am_in_ready;
   assign ready2 = !valid2_ff || ready3;
   assign ready1 = !valid1_ff || ready2;
   assign req_stall = !ready1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid6_ff <= 1'b0;
      end else begin
         if (ready1) valid1_ff <= req_valid;
         if (ready2) valid2_ff <= valid1_ff;
         if (ready3) valid3_ff <= valid2_ff;
         if (ready6) valid6_ff <= am_out_valid;
      end
   end

   // ---------------- stage 1: absolute channel differences ----------------
   // channel 0 red, 1 green, 2 blue - same order as the bytes of an entry
   logic [ChanW-1:0] diff_in [PALETTE_ENTRIES][3];
   logic [ChanW-1:0] diff_ff [PALETTE_ENTRIES][3];
   logic [ChanW-1:0] pix [3];

   assign pix[0] = req_pixel_red;
   assign pix[1] = req_pixel_green;
   assign pix[2] = req_pixel_blue;

   always_comb begin
      logic [ChanW-1:0] pal_chan;
      for (int k = 0; k < PALETTE_ENTRIES; k++) begin
         for (int c = 0; c < 3; c++) begin
            pal_chan = palette[k][c*ChanW +: ChanW];
            diff_in[k][c] = (pix[c] >= pal_chan) ? (pix[c] - pal_chan)
                                                 : (pal_chan - pix[c]);
         end
      end
   end

   // ---------------- stage 2: squares ----------------
   logic [SqW-1:0] sq_in [PALETTE_ENTRIES][3];
   logic [SqW-1:0] sq_ff [PALETTE_ENTRIES][3];

   always_comb begin
      for (int k = 0; k < PALETTE_ENTRIES; k++) begin
         for (int c = 0; c < 3; c++) begin
            sq_in[k][c] = SqW'(diff_ff[k][c]) * SqW'(diff_ff[k][c]);
         end
      end
   end

   // ---------------- stage 3: distance per entry ----------------
   logic [DistW-1:0] dist_in [PALETTE_ENTRIES];
   logic [DistW-1:0] dist_ff [PALETTE_ENTRIES];

   always_comb begin
      for (int k = 0; k < PALETTE_ENTRIES; k++) begin
         dist_in[k] = DistW'(sq_ff[k][0]) + DistW'(sq_ff[k][1]) + DistW'(sq_ff[k][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) diff_ff <= diff_in;
      if (ready2) sq_ff   <= sq_in;
      if (ready3) dist_ff <= dist_in;
   end

   // ---------------- stages 4-5: minimum search ----------------
   npc_argmin #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_argmin (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid3_ff),
      .in_ready  (am_in_ready),
      .in_dist   (dist_ff),
      .out_valid (am_out_valid),
      .out_ready (ready6),
      .out_index (am_index)
   );

   // ---------------- stage 6: colour lookup, output register ----------------
   logic [npc_pkg::IDX_W-1:0] index_ff;
   logic [EntryW-1:0]         colour_ff;

   always_ff @(posedge clock) begin
      if (ready6) begin
         index_ff  <= am_index;
         colour_ff <= palette[am_index];
      end
   end

   assign rsp_valid        = valid6_ff;
   assign rsp_chosen_index = index_ff;
   assign rsp_chosen_red   = colour_ff[0*ChanW +: ChanW];
   assign rsp_chosen_green = colour_ff[1*ChanW +: ChanW];
   assign rsp_chosen_blue  = colour_ff[2*ChanW +: ChanW];

   // ---------------- checks ----------------
   a_pipe_empty_after_reset: assert property (@(posedge clock)
      reset |=> (!valid1_ff && !valid2_ff && !valid3_ff && !valid6_ff))
      else $error("pipe not empty after reset");

   a_no_stall_when_first_free: assert property (@(posedge clock) disable iff (reset)
      !valid1_ff |-> !req_stall)
      else $error("input stalled with first stage empty");

   a_result_index_in_range: assert property (@(posedge clock) disable iff (reset)
      valid6_ff |-> (32'(index_ff) < PALETTE_ENTRIES))
      else $error("result index beyond searched entries");

endmodule

`default_nettype wire
